/* src/bffa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package bffa_pkg;

  // default geometry of the bitmap
  localparam int BitmapBitsDef = 32768;
  localparam int WordWidthDef  = 32;

  // fixed field widths
  localparam int CmdW      = 2;
  localparam int WordIdxW  = 10;
  localparam int WordDataW = 32;
  localparam int TotalW    = 32;
  localparam int GroupW    = 16;
  localparam int IndexW    = 16;
  localparam int CfgDataW  = 16;

  // configuration register indexes
  localparam logic CfgMaxBits  = 1'b0;
  localparam logic CfgOneBased = 1'b1;

  // configuration reset values
  localparam logic [CfgDataW-1:0] MaxBitsReset = 16'd8192;

  // request commands
  typedef enum logic [CmdW-1:0] {
    CmdLoadWord   = 2'd0,
    CmdLoadCounts = 2'd1,
    CmdAlloc      = 2'd2,
    CmdNone       = 2'd3
  } cmd_e;

  // controller states
  typedef enum logic [1:0] {
    StIdle = 2'd0,
    StScan = 2'd1,
    StResp = 2'd2
  } state_e;

  // one result item
  typedef struct packed {
    logic              found;
    logic [IndexW-1:0] alloc_index;
    logic [TotalW-1:0] total_free;
    logic [GroupW-1:0] group_free;
  } res_t;

endpackage

`default_nettype wire

/* src/bffa_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module bffa_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* src/bffa_find.sv */
`timescale 1ns / 1ps
`default_nettype none

module bffa_find #(
  parameter int WordWidth = 32,
  parameter int BaseW     = 18,
  localparam int BitW = $clog2(WordWidth)
) (
  input  wire logic [WordWidth-1:0] word_i,
  input  wire logic [BaseW-1:0]     base_i,
  input  wire logic [BaseW-1:0]     limit_i,
  output logic                      hit_o,
  output logic      [BitW-1:0]      bit_o,
  output logic      [WordWidth-1:0] set_mask_o
);

  logic [BaseW-1:0]     rem;
  logic                 all_elig;
  logic [BitW-1:0]      shamt;
  logic [WordWidth-1:0] elig;
  logic [WordWidth-1:0] free;

  // bits of this word that still lie below the limit
  assign rem      = limit_i - base_i;
  assign all_elig = (32'(rem) >= WordWidth);
  assign shamt    = rem[BitW-1:0];

  always_comb begin
    for (int b = 0; b < WordWidth; b++) begin
      elig[b] = all_elig || (BitW'(b) < shamt);
    end
  end

  assign free = ~word_i & elig;

  // lowest free eligible bit
  always_comb begin
    bit_o = '0;
    for (int b = WordWidth - 1; b >= 0; b--) begin
      if (free[b]) begin
        bit_o = BitW'(b);
      end
    end
  end

  assign hit_o      = |free;
  assign set_mask_o = {{(WordWidth-1){1'b0}}, 1'b1} << bit_o;

endmodule

`default_nettype wire

/* src/bffa_out_buf.sv */
`timescale 1ns / 1ps
`default_nettype none

module bffa_out_buf (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  output logic                 ready_o,
  input  wire bffa_pkg::res_t  data_i,
  output logic                 valid_o,
  input  wire logic            ready_i,
  output bffa_pkg::res_t       data_o
);

  logic           valid_q, valid_d;
  bffa_pkg::res_t data_q, data_d;

  // slot is free when empty or being drained this cycle
  assign ready_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (valid_i && ready_o) begin
      valid_d = 1'b1;
      data_d  = data_i;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

/* src/bitmap_first_free_allocator.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake                 payload
// -------   ---------  ------------------------  ----------------------------------------
// in        input      in_valid_i / in_ready_o   cmd, word_index, word_data, counts in
// out       output     out_valid_o / out_ready_i found, alloc_index, total_free, group_free
// cfg       input      cfg_we_i (no wait)        cfg_index_i, cfg_wdata_i
//
// load word, load counts, unused commands and a zero-limit allocate go straight to the
// response step. allocate scans from word 0 and stops at the word that holds the bit, or at
// the last word below the limit on a miss: the single read port of the bitmap RAM streams
// one word per cycle.
// one request is in flight at a time; in_ready_o is high in the idle step only.
// a full output register holds the finished request in the response step.
// reset clears counts and sets configuration to its reset values; the bitmap RAM has no reset and no clearing pass.

module bitmap_first_free_allocator #(
  parameter int BitmapBits = bffa_pkg::BitmapBitsDef,
  parameter int WordWidth  = bffa_pkg::WordWidthDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [bffa_pkg::CmdW-1:0]      cmd_i,
  input  wire logic [bffa_pkg::WordIdxW-1:0]  word_index_i,
  input  wire logic [bffa_pkg::WordDataW-1:0] word_data_i,
  input  wire logic [bffa_pkg::TotalW-1:0]    total_free_in_i,
  input  wire logic [bffa_pkg::GroupW-1:0]    group_free_in_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic                                found_o,
  output logic      [bffa_pkg::IndexW-1:0]    alloc_index_o,
  output logic      [bffa_pkg::TotalW-1:0]    total_free_o,
  output logic      [bffa_pkg::GroupW-1:0]    group_free_o,
  input  wire logic                           cfg_we_i,
  input  wire logic                           cfg_index_i,
  input  wire logic [bffa_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  localparam int NumWords  = BitmapBits / WordWidth;
  localparam int AddrW     = (NumWords > 1) ? $clog2(NumWords) : 1;
  localparam int TotalBits = NumWords * WordWidth;
  localparam int BaseW     = $clog2(BitmapBits + 1) + 1;
  localparam int BitW      = $clog2(WordWidth);

  // configuration registers
  logic [bffa_pkg::CfgDataW-1:0] max_bits_q;
  logic                          one_based_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bits_q  <= bffa_pkg::MaxBitsReset;
      one_based_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        bffa_pkg::CfgMaxBits:  max_bits_q  <= cfg_wdata_i;
        bffa_pkg::CfgOneBased: one_based_q <= cfg_wdata_i[0];
        default:               max_bits_q  <= max_bits_q;
      endcase
    end
  end

  // control and datapath registers
  bffa_pkg::state_e              state_q, state_d;
  logic [bffa_pkg::TotalW-1:0]   total_free_q, total_free_d;
  logic [bffa_pkg::GroupW-1:0]   group_free_q, group_free_d;
  logic [BaseW-1:0]              limit_q, limit_d;
  logic [AddrW-1:0]              rd_ptr_q, rd_ptr_d;
  logic [BaseW-1:0]              rd_base_q, rd_base_d;
  logic                          chk_vld_q, chk_vld_d;
  logic [AddrW-1:0]              chk_word_q, chk_word_d;
  logic [BaseW-1:0]              chk_base_q, chk_base_d;
  logic                          res_found_q, res_found_d;
  logic [bffa_pkg::IndexW-1:0]   res_index_q, res_index_d;

  // memory port signals
  logic                 ram_we;
  logic [AddrW-1:0]     ram_waddr;
  logic [WordWidth-1:0] ram_wdata;
  logic                 ram_re;
  logic [WordWidth-1:0] ram_rdata;

  // helpers
  logic                 in_fire;
  bffa_pkg::cmd_e       cmd;
  logic [31:0]          lim_full;
  logic [BaseW-1:0]     lim_new;
  logic                 issue;
  logic                 hit;
  logic [BitW-1:0]      hit_bit;
  logic [WordWidth-1:0] hit_mask;
  logic                 last_word;
  logic                 word_in_range;
  logic                 resp_ready;
  logic [31:0]          index_full;
  bffa_pkg::res_t       res_data;
  bffa_pkg::res_t       out_data;

  assign in_ready_o    = (state_q == bffa_pkg::StIdle);
  assign in_fire       = in_valid_i && in_ready_o;
  assign cmd           = bffa_pkg::cmd_e'(cmd_i);
  assign lim_full      = (32'(max_bits_q) > TotalBits) ? TotalBits : 32'(max_bits_q);
  assign lim_new       = BaseW'(lim_full);
  assign issue         = (rd_base_q < limit_q);
  assign last_word     = (32'(chk_base_q) + WordWidth >= 32'(limit_q));
  assign word_in_range = (32'(word_index_i) < NumWords);
  assign index_full    = 32'(chk_base_q) + 32'(hit_bit) + 32'(one_based_q);

  // bitmap storage
  bffa_ram #(
    .Width (WordWidth),
    .Depth (NumWords)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_ptr_q),
    .rdata_o (ram_rdata)
  );

  // check of the word that arrives from the RAM
  bffa_find #(
    .WordWidth (WordWidth),
    .BaseW     (BaseW)
  ) u_find (
    .word_i     (ram_rdata),
    .base_i     (chk_base_q),
    .limit_i    (limit_q),
    .hit_o      (hit),
    .bit_o      (hit_bit),
    .set_mask_o (hit_mask)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bffa_pkg::StIdle: begin
        if (in_fire) begin
          if (cmd == bffa_pkg::CmdAlloc && lim_new != '0) begin
            state_d = bffa_pkg::StScan;
          end else begin
            state_d = bffa_pkg::StResp;
          end
        end
      end
      bffa_pkg::StScan: begin
        if (chk_vld_q && (hit || last_word)) begin
          state_d = bffa_pkg::StResp;
        end
      end
      bffa_pkg::StResp: begin
        if (resp_ready) begin
          state_d = bffa_pkg::StIdle;
        end
      end
      default: state_d = bffa_pkg::StIdle;
    endcase
  end

  // datapath and memory control
  always_comb begin
    total_free_d = total_free_q;
    group_free_d = group_free_q;
    limit_d      = limit_q;
    rd_ptr_d     = rd_ptr_q;
    rd_base_d    = rd_base_q;
    chk_vld_d    = chk_vld_q;
    chk_word_d   = chk_word_q;
    chk_base_d   = chk_base_q;
    res_found_d  = res_found_q;
    res_index_d  = res_index_q;
    ram_we       = 1'b0;
    ram_waddr    = chk_word_q;
    ram_wdata    = ram_rdata | hit_mask;
    ram_re       = 1'b0;
    unique case (state_q)
      bffa_pkg::StIdle: begin
        if (in_fire) begin
          res_found_d = 1'b0;
          res_index_d = '0;
          rd_ptr_d    = '0;
          rd_base_d   = '0;
          chk_vld_d   = 1'b0;
          limit_d     = lim_new;
          unique case (cmd)
            bffa_pkg::CmdLoadWord: begin
              ram_we    = word_in_range;
              ram_waddr = AddrW'(word_index_i);
              ram_wdata = WordWidth'(word_data_i);
            end
            bffa_pkg::CmdLoadCounts: begin
              total_free_d = total_free_in_i;
              group_free_d = group_free_in_i;
            end
            default: begin
            end
          endcase
        end
      end
      bffa_pkg::StScan: begin
        // stream one word read per cycle
        ram_re     = issue;
        chk_vld_d  = issue;
        chk_word_d = rd_ptr_q;
        chk_base_d = rd_base_q;
        if (issue) begin
          rd_ptr_d  = rd_ptr_q + AddrW'(1);
          rd_base_d = rd_base_q + BaseW'(WordWidth);
        end
        // claim the bit and write the word back
        if (chk_vld_q && hit) begin
          ram_we      = 1'b1;
          res_found_d = 1'b1;
          res_index_d = index_full[bffa_pkg::IndexW-1:0];
          if (total_free_q != '0) begin
            total_free_d = total_free_q - 1'b1;
          end
          if (group_free_q != '0) begin
            group_free_d = group_free_q - 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= bffa_pkg::StIdle;
      total_free_q <= '0;
      group_free_q <= '0;
      chk_vld_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      total_free_q <= total_free_d;
      group_free_q <= group_free_d;
      chk_vld_q    <= chk_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    limit_q     <= limit_d;
    rd_ptr_q    <= rd_ptr_d;
    rd_base_q   <= rd_base_d;
    chk_word_q  <= chk_word_d;
    chk_base_q  <= chk_base_d;
    res_found_q <= res_found_d;
    res_index_q <= res_index_d;
  end

  // result into the output register
  assign res_data.found       = res_found_q;
  assign res_data.alloc_index = res_index_q;
  assign res_data.total_free  = total_free_q;
  assign res_data.group_free  = group_free_q;

  bffa_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (state_q == bffa_pkg::StResp),
    .ready_o (resp_ready),
    .data_i  (res_data),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data)
  );

  assign found_o       = out_data.found;
  assign alloc_index_o = out_data.alloc_index;
  assign total_free_o  = out_data.total_free;
  assign group_free_o  = out_data.group_free;

`ifndef SYNTHESIS
  // a word under check was read while still below the limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    chk_vld_q && (state_q == bffa_pkg::StScan) |-> (chk_base_q < limit_q))
    else $error("word under check lies past the limit");

  // a scan never runs with an empty range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bffa_pkg::StScan) |-> (limit_q != '0))
    else $error("scan started with zero limit");

  // write-back during a scan only for a checked word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bffa_pkg::StScan) && ram_we |-> chk_vld_q && hit)
    else $error("bitmap written without a claimed bit");

  // free counts only go down during a scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bffa_pkg::StScan) |=> (total_free_q <= $past(total_free_q)) &&
                                      (group_free_q <= $past(group_free_q)))
    else $error("free count grew during allocate");
`endif

endmodule

`default_nettype wire
